// ===== rtl/core/rbbp_pkg.sv =====
// Shared constants and types of the reference-counted bitmap block pool.
package rbbp_pkg;

  localparam int MAP_WORDS_DEF = 8;
  localparam int MAX_REFS_DEF  = 8;

  localparam int CMD_W    = 2;
  localparam int BLK_W    = 8;
  localparam int CNT_W    = 4;
  localparam int NB_W     = 9;
  localparam int STATUS_W = 2;
  localparam int MAP_W    = 32;

  localparam int COUNT_DEPTH = 256;

  localparam logic [NB_W-1:0]  NB_RESET = 9'd256;
  localparam logic [MAP_W-1:0] TOP_BIT  = 32'h8000_0000;
  localparam logic [BLK_W-1:0] BIT_MASK = 8'h1F;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_ADDREF  = 2'd2,
    CMD_INIT    = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_LIMIT = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_INIT = 4'b0010,
    S_EXEC = 4'b0100,
    S_RESP = 4'b1000
  } state_t;

endpackage

// ===== rtl/core/rbbp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module rbbp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/refcounted_bitmap_block_pool_unit.sv =====
// Top level of the reference-counted bitmap block pool: sequencer, free map and count stores.
//
//  channel | direction | handshake         | word
//  in_     | input     | in_valid/in_stall | in_cmd, in_block_index
//  out_    | output    | out_valid/out_stall | out_status, out_result_block, out_refs_after
//  cfg_    | input     | cfg_we            | cfg_wdata (num_blocks)
//
// Allocate, release and add reference pass from acceptance to the result register through
// the registered read of the map and count RAMs, the update state and the hand-over state.
// An allocate on an empty pool goes straight from acceptance to the hand-over; init first
// runs the one-word-per-cycle write sweep over the free-map RAM, then hands over.
// After reset neither RAM is swept: per-word and per-block valid bits make unwritten
// entries read as zero. One word may wait at the output while the next is accepted.
module refcounted_bitmap_block_pool_unit #(
  parameter int MAP_WORDS = rbbp_pkg::MAP_WORDS_DEF,
  parameter int MAX_REFS  = rbbp_pkg::MAX_REFS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rbbp_pkg::NB_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rbbp_pkg::CMD_W-1:0]     in_cmd,
  input  logic [rbbp_pkg::BLK_W-1:0]     in_block_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rbbp_pkg::STATUS_W-1:0]  out_status,
  output logic [rbbp_pkg::BLK_W-1:0]     out_result_block,
  output logic [rbbp_pkg::CNT_W-1:0]     out_refs_after
);

  import rbbp_pkg::*;

  localparam int MW_AW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CAP_INT = (MAP_WORDS * MAP_W < COUNT_DEPTH) ? MAP_WORDS * MAP_W : COUNT_DEPTH;
  localparam logic [NB_W-1:0]  CAP      = NB_W'(CAP_INT);
  localparam logic [CNT_W-1:0] REF_LIM  = CNT_W'(MAX_REFS);
  localparam logic [MW_AW-1:0] LAST_W   = MW_AW'(MAP_WORDS - 1);
  localparam int CA_W = $clog2(COUNT_DEPTH);

  // Leading-zero count from the MSB; the word is known to be non-zero.
  function automatic logic [4:0] lzc32(input logic [MAP_W-1:0] v);
    logic [4:0] n;
    n = 5'd31;
    for (int i = 0; i < MAP_W; i++) begin
      if (v[i]) begin
        n = 5'(MAP_W - 1 - i);
      end
    end
    return n;
  endfunction

  // Free-map word written by init: block k is free when k is below the limit.
  function automatic logic [MAP_W-1:0] init_word(input logic [MW_AW-1:0] idx,
                                                 input logic [NB_W-1:0] limit);
    logic [11:0] base;
    logic [11:0] lim;
    logic [11:0] rem;
    logic [MAP_W-1:0] w;
    base = 12'(idx) << 5;
    lim  = 12'(limit);
    rem  = lim - base;
    if (lim <= base) begin
      w = '0;
    end else if (rem >= 12'd32) begin
      w = '1;
    end else begin
      w = ~({MAP_W{1'b1}} >> rem[4:0]);
    end
    return w;
  endfunction

  state_t             state_r, state_nxt;
  cmd_t               op_r, op_nxt;
  logic [BLK_W-1:0]   blk_r, blk_nxt;
  logic [MW_AW-1:0]   word_r, word_nxt;
  logic               in_map_r, in_map_nxt;
  logic               map_vq_r, map_vq_nxt;
  logic               cnt_vq_r, cnt_vq_nxt;
  logic [MW_AW-1:0]   idx_r, idx_nxt;
  logic [NB_W-1:0]    limit_r, limit_nxt;
  logic [NB_W-1:0]    num_blocks_r;

  status_t            res_status_r, res_status_nxt;
  logic [BLK_W-1:0]   res_blk_r, res_blk_nxt;
  logic [CNT_W-1:0]   res_refs_r, res_refs_nxt;

  logic [MAP_WORDS-1:0]   nz_r;
  logic [MAP_WORDS-1:0]   map_vld_r;
  logic [COUNT_DEPTH-1:0] cnt_vld_r;
  logic                   cnt_clr;

  logic               out_valid_r;
  status_t            out_status_r;
  logic [BLK_W-1:0]   out_blk_r;
  logic [CNT_W-1:0]   out_refs_r;
  logic               out_load;

  logic               in_take;
  cmd_t               in_op;
  logic [2:0]         in_word;
  logic               in_in_map;
  logic [MW_AW-1:0]   first_w;
  logic               any_nz;

  logic               map_we;
  logic [MW_AW-1:0]   map_waddr;
  logic [MAP_W-1:0]   map_wdata;
  logic [MW_AW-1:0]   map_raddr;
  logic [MAP_W-1:0]   map_rdata;
  logic               cnt_we;
  logic [CA_W-1:0]    cnt_waddr;
  logic [CNT_W-1:0]   cnt_wdata;
  logic [CNT_W-1:0]   cnt_rdata;

  logic [MAP_W-1:0]   cur_word;
  logic [CNT_W-1:0]   cur_cnt;
  logic [4:0]         alloc_n;
  logic [BLK_W-1:0]   alloc_blk;
  logic [MAP_W-1:0]   blk_bit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign in_op     = cmd_t'(in_cmd);
  assign in_word   = in_block_index[7:5];
  assign in_in_map = (32'(in_word) < MAP_WORDS);

  always_comb begin
    first_w = '0;
    any_nz  = 1'b0;
    for (int i = MAP_WORDS - 1; i >= 0; i--) begin
      if (nz_r[i]) begin
        first_w = MW_AW'(i);
        any_nz  = 1'b1;
      end
    end
  end

  assign map_raddr = (in_op == CMD_ALLOC) ? first_w : MW_AW'(in_word);

  rbbp_ram #(.WIDTH(MAP_W), .DEPTH(MAP_WORDS), .AW(MW_AW)) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .re    (in_take),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  rbbp_ram #(.WIDTH(CNT_W), .DEPTH(COUNT_DEPTH), .AW(CA_W)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .re    (in_take),
    .raddr (CA_W'(in_block_index)),
    .rdata (cnt_rdata)
  );

  assign cur_word  = map_vq_r ? map_rdata : '0;
  assign cur_cnt   = cnt_vq_r ? cnt_rdata : '0;
  assign alloc_n   = lzc32(cur_word);
  assign alloc_blk = 8'({word_r, alloc_n});
  assign blk_bit   = TOP_BIT >> (blk_r & BIT_MASK);
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    blk_nxt        = blk_r;
    word_nxt       = word_r;
    in_map_nxt     = in_map_r;
    map_vq_nxt     = map_vq_r;
    cnt_vq_nxt     = cnt_vq_r;
    idx_nxt        = idx_r;
    limit_nxt      = limit_r;
    res_status_nxt = res_status_r;
    res_blk_nxt    = res_blk_r;
    res_refs_nxt   = res_refs_r;
    cnt_clr        = 1'b0;
    map_we         = 1'b0;
    map_waddr      = idx_r;
    map_wdata      = init_word(idx_r, limit_r);
    cnt_we         = 1'b0;
    cnt_waddr      = CA_W'(blk_r);
    cnt_wdata      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_take) begin
          op_nxt     = in_op;
          blk_nxt    = in_block_index;
          in_map_nxt = in_in_map;
          word_nxt   = map_raddr;
          map_vq_nxt = map_vld_r[map_raddr];
          cnt_vq_nxt = cnt_vld_r[CA_W'(in_block_index)];
          if (in_op == CMD_INIT) begin
            cnt_clr   = 1'b1;
            idx_nxt   = '0;
            limit_nxt = (num_blocks_r > CAP) ? CAP : num_blocks_r;
            state_nxt = S_INIT;
          end else if (in_op == CMD_ALLOC && !any_nz) begin
            res_status_nxt = ST_EMPTY;
            res_blk_nxt    = '0;
            res_refs_nxt   = '0;
            state_nxt      = S_RESP;
          end else begin
            state_nxt = S_EXEC;
          end
        end
      end
      S_INIT: begin
        map_we = 1'b1;
        if (idx_r == LAST_W) begin
          res_status_nxt = ST_OK;
          res_blk_nxt    = '0;
          res_refs_nxt   = '0;
          state_nxt      = S_RESP;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_EXEC: begin
        state_nxt      = S_RESP;
        res_status_nxt = ST_OK;
        res_blk_nxt    = blk_r;
        res_refs_nxt   = cur_cnt;
        map_waddr      = word_r;
        case (op_r)
          CMD_ALLOC: begin
            map_we       = 1'b1;
            map_wdata    = cur_word & ~(TOP_BIT >> alloc_n);
            cnt_we       = 1'b1;
            cnt_waddr    = CA_W'(alloc_blk);
            cnt_wdata    = CNT_W'(1);
            res_blk_nxt  = alloc_blk;
            res_refs_nxt = CNT_W'(1);
          end
          CMD_RELEASE: begin
            if (in_map_r) begin
              cnt_we = 1'b1;
              if (cur_cnt > CNT_W'(1)) begin
                cnt_wdata    = cur_cnt - 1'b1;
                res_refs_nxt = cur_cnt - 1'b1;
              end else begin
                map_we       = 1'b1;
                map_wdata    = cur_word | blk_bit;
                cnt_wdata    = '0;
                res_refs_nxt = '0;
              end
            end
          end
          CMD_ADDREF: begin
            if (in_map_r) begin
              if (cur_cnt >= REF_LIM) begin
                res_status_nxt = ST_LIMIT;
              end else begin
                cnt_we       = 1'b1;
                cnt_wdata    = cur_cnt + 1'b1;
                res_refs_nxt = cur_cnt + 1'b1;
              end
            end
          end
          default: begin
          end
        endcase
      end
      S_RESP: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      num_blocks_r <= NB_RESET;
      nz_r         <= '0;
      map_vld_r    <= '0;
      cnt_vld_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        num_blocks_r <= cfg_wdata;
      end
      if (map_we) begin
        nz_r[map_waddr]      <= (map_wdata != '0);
        map_vld_r[map_waddr] <= 1'b1;
      end
      if (cnt_clr) begin
        cnt_vld_r <= '0;
      end else if (cnt_we) begin
        cnt_vld_r[cnt_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    blk_r        <= blk_nxt;
    word_r       <= word_nxt;
    in_map_r     <= in_map_nxt;
    map_vq_r     <= map_vq_nxt;
    cnt_vq_r     <= cnt_vq_nxt;
    idx_r        <= idx_nxt;
    limit_r      <= limit_nxt;
    res_status_r <= res_status_nxt;
    res_blk_r    <= res_blk_nxt;
    res_refs_r   <= res_refs_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_blk_r    <= res_blk_r;
      out_refs_r   <= res_refs_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_result_block = out_blk_r;
  assign out_refs_after   = out_refs_r;

  // An accepted word always leaves the idle state, so no RAM access can overlap the next read.
  a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r != S_IDLE)
    else $error("accepted word did not start a command");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_RESP) |-> !map_we && !cnt_we)
    else $error("RAM write outside the update or init states");

  // The per-word flag that steers allocate must follow the data written to that word.
  a_nz_tracks_map: assert property (@(posedge clk) disable iff (!rst_n)
    map_we |=> nz_r[$past(map_waddr)] == ($past(map_wdata) != '0))
    else $error("non-zero flag out of step with free map");

  a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC && op_r == CMD_ALLOC) |=>
      res_status_r == ST_OK && res_refs_r == CNT_W'(1))
    else $error("allocate from a non-empty word gave a wrong result");

  a_refs_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_refs_r <= REF_LIM)
    else $error("reference count above the limit");

endmodule
